@@ rtl/ofat_pkg.sv @@
// ----------------------------------------------------------------------------
// OFDM frame airtime calculator package
// Shared widths, rate tables and stage payload types.
// ----------------------------------------------------------------------------
package ofat_pkg;

    localparam int LEN_W      = 12;
    localparam int RATE_W     = 3;
    localparam int SYMTIME_W  = 14;
    localparam int SYMBOLS_W  = 11;
    localparam int DURATION_W = 25;

    // Numerator of the rounded-up division: 22 + 8*length + divisor - 1.
    localparam int NUM_W      = 16;

    // Reciprocal scaling; the divisors are all below 2**(DIV_SHIFT - NUM_W).
    localparam int DIV_SHIFT  = 24;
    localparam int RECIP_W    = 20;
    localparam int PROD_W     = NUM_W + RECIP_W;

    localparam int BPS_W      = 8;
    localparam int SERVICE_TAIL_BITS = 22;
    localparam int OVERHEAD_SYMBOLS  = 5;
    localparam logic [SYMTIME_W-1:0] SYMTIME_RESET = SYMTIME_W'(4000);

    localparam int NUM_RATES = 8;

    localparam logic [BPS_W-1:0] BPS_TABLE [NUM_RATES] = '{
        8'd24, 8'd36, 8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd216
    };

    // ceil(2**DIV_SHIFT / d) for each rate's data bits per symbol.
    localparam logic [RECIP_W-1:0] RECIP_TABLE [NUM_RATES] = '{
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd23)  / 64'd24),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd35)  / 64'd36),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd47)  / 64'd48),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd71)  / 64'd72),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd95)  / 64'd96),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd143) / 64'd144),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd191) / 64'd192),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd215) / 64'd216)
    };

    typedef struct packed {
        logic               valid;
        logic [NUM_W-1:0]   num;
        logic [RECIP_W-1:0] recip;
    } prep_t;

    typedef struct packed {
        logic                 valid;
        logic [SYMBOLS_W-1:0] symbols;
    } quot_t;

endpackage

@@ rtl/ofat_prep.sv @@
// ----------------------------------------------------------------------------
// OFDM airtime front stage
// Forms the rounded-up numerator and picks the reciprocal for the rate.
// ----------------------------------------------------------------------------
module ofat_prep
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [ofat_pkg::LEN_W-1:0]      length_bytes,
    input  logic [ofat_pkg::RATE_W-1:0]     rate_index,
    output ofat_pkg::prep_t                 prep
);

    logic                                valid_reg;
    logic [ofat_pkg::NUM_W-1:0]          num_reg;
    logic [ofat_pkg::NUM_W-1:0]          num_next;
    logic [ofat_pkg::RECIP_W-1:0]        recip_reg;
    logic [ofat_pkg::BPS_W-1:0]          bps;

    always_comb
    begin
        bps      = ofat_pkg::BPS_TABLE[rate_index];
        // Adding divisor - 1 turns the floor division into a ceiling.
        num_next = ofat_pkg::NUM_W'(ofat_pkg::SERVICE_TAIL_BITS)
                 + {1'b0, length_bytes, 3'b000}
                 + {{(ofat_pkg::NUM_W - ofat_pkg::BPS_W){1'b0}}, bps}
                 - ofat_pkg::NUM_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            num_reg   <= num_next;
            recip_reg <= ofat_pkg::RECIP_TABLE[rate_index];
        end
    end

    assign prep.valid = valid_reg;
    assign prep.num   = num_reg;
    assign prep.recip = recip_reg;

endmodule

@@ rtl/ofat_div.sv @@
// ----------------------------------------------------------------------------
// OFDM airtime divider stage
// Divides by the data bits per symbol through a reciprocal multiplication.
// ----------------------------------------------------------------------------
module ofat_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  ofat_pkg::prep_t  prep,
    output ofat_pkg::quot_t  quot
);

    logic                               valid_reg;
    logic [ofat_pkg::SYMBOLS_W-1:0]     symbols_reg;
    logic [ofat_pkg::PROD_W-1:0]        prod;

    // The reciprocal error is below 2**(DIV_SHIFT - NUM_W), so the quotient is exact.
    assign prod = {{ofat_pkg::RECIP_W{1'b0}}, prep.num}
                * {{ofat_pkg::NUM_W{1'b0}}, prep.recip};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prep.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep.valid)
        begin
            symbols_reg <=
                prod[ofat_pkg::DIV_SHIFT + ofat_pkg::SYMBOLS_W - 1 : ofat_pkg::DIV_SHIFT];
        end
    end

    assign quot.valid   = valid_reg;
    assign quot.symbols = symbols_reg;

endmodule

@@ rtl/ofat_dur.sv @@
// ----------------------------------------------------------------------------
// OFDM airtime duration stage
// Adds the preamble and header symbols and scales by the symbol time.
// ----------------------------------------------------------------------------
module ofat_dur
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ofat_pkg::quot_t                    quot,
    input  logic [ofat_pkg::SYMTIME_W-1:0]     symbol_time,
    output logic                               done,
    output logic [ofat_pkg::SYMBOLS_W-1:0]     data_symbols,
    output logic [ofat_pkg::DURATION_W-1:0]    duration_ns
);

    localparam int TOTAL_W = ofat_pkg::SYMBOLS_W + 1;
    localparam int MUL_W   = TOTAL_W + ofat_pkg::SYMTIME_W;

    logic                               done_reg;
    logic [ofat_pkg::SYMBOLS_W-1:0]     symbols_reg;
    logic [ofat_pkg::DURATION_W-1:0]    duration_reg;
    logic [TOTAL_W-1:0]                 total_symbols;
    logic [MUL_W-1:0]                   duration_next;

    always_comb
    begin
        total_symbols = {1'b0, quot.symbols} + TOTAL_W'(ofat_pkg::OVERHEAD_SYMBOLS);
        duration_next = {{ofat_pkg::SYMTIME_W{1'b0}}, total_symbols}
                      * {{TOTAL_W{1'b0}}, symbol_time};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= quot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quot.valid)
        begin
            symbols_reg  <= quot.symbols;
            duration_reg <= duration_next[ofat_pkg::DURATION_W-1:0];
        end
    end

    assign done         = done_reg;
    assign data_symbols = symbols_reg;
    assign duration_ns  = duration_reg;

endmodule

@@ rtl/ofdm_frame_airtime_calc.sv @@
// ----------------------------------------------------------------------------
// OFDM frame airtime calculator
// Path: an accepted request passes the prep, div and duration registers.
// Throughput: one request per cycle; busy is never raised.
// Stages: numerator and reciprocal, reciprocal multiply, duration multiply.
// Reset clears the pipeline valid bits and sets the symbol time to 4000 ns.
// Results cannot be held off by the receiver; done lasts one cycle.
// ----------------------------------------------------------------------------
module ofdm_frame_airtime_calc
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ofat_pkg::LEN_W-1:0]         length_bytes,
    input  logic [ofat_pkg::RATE_W-1:0]        rate_index,
    input  logic                               cfg_we,
    input  logic [ofat_pkg::SYMTIME_W-1:0]     cfg_wdata,
    output logic                               done,
    output logic [ofat_pkg::SYMBOLS_W-1:0]     data_symbols,
    output logic [ofat_pkg::DURATION_W-1:0]    duration_ns
);

    logic [ofat_pkg::SYMTIME_W-1:0] symbol_time_reg;
    logic                           accept;
    ofat_pkg::prep_t                prep;
    ofat_pkg::quot_t                quot;

    // Every stage advances each cycle, so a new request is always taken.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_time_reg <= ofat_pkg::SYMTIME_RESET;
        end
        else if (cfg_we)
        begin
            symbol_time_reg <= cfg_wdata;
        end
    end

    ofat_prep u_prep
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .length_bytes (length_bytes),
        .rate_index   (rate_index),
        .prep         (prep)
    );

    ofat_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .prep  (prep),
        .quot  (quot)
    );

    ofat_dur u_dur
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .quot         (quot),
        .symbol_time  (symbol_time_reg),
        .done         (done),
        .data_symbols (data_symbols),
        .duration_ns  (duration_ns)
    );

endmodule

@@ rtl/ofat_checker.sv @@
// ----------------------------------------------------------------------------
// OFDM airtime port checker
// Watches the top level ports for request timing and result sanity.
// ----------------------------------------------------------------------------
module ofat_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [ofat_pkg::LEN_W-1:0]         length_bytes,
    input  logic [ofat_pkg::RATE_W-1:0]        rate_index,
    input  logic                               done,
    input  logic [ofat_pkg::SYMBOLS_W-1:0]     data_symbols,
    input  logic [ofat_pkg::DURATION_W-1:0]    duration_ns
);

    logic                            req;
    logic [31:0]                     past_bits;
    logic [31:0]                     past_bps;
    logic [31:0]                     sym_bits;
    logic [ofat_pkg::LEN_W-1:0]      len_d1_reg;
    logic [ofat_pkg::LEN_W-1:0]      len_d2_reg;
    logic [ofat_pkg::LEN_W-1:0]      len_d3_reg;
    logic [ofat_pkg::RATE_W-1:0]     rate_d1_reg;
    logic [ofat_pkg::RATE_W-1:0]     rate_d2_reg;
    logic [ofat_pkg::RATE_W-1:0]     rate_d3_reg;

    // The request fields pass through three delay registers to line up with the result.
    always_ff @(posedge clk)
    begin
        len_d1_reg  <= length_bytes;
        len_d2_reg  <= len_d1_reg;
        len_d3_reg  <= len_d2_reg;
        rate_d1_reg <= rate_index;
        rate_d2_reg <= rate_d1_reg;
        rate_d3_reg <= rate_d2_reg;
    end

    assign req       = start & ~busy & rst_n;
    assign past_bits = 32'(ofat_pkg::SERVICE_TAIL_BITS)
                     + {17'd0, len_d3_reg, 3'b000};
    assign past_bps  = {24'd0, ofat_pkg::BPS_TABLE[rate_d3_reg]};
    assign sym_bits  = {21'd0, data_symbols} * past_bps;

    // Every request gets its result once it has passed the pipeline.
    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req |-> ##3 done)
        else $error("request produced no result after three cycles");

    // No result appears without a matching earlier request.
    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req, 3))
        else $error("result without a matching request");

    // The symbol count is the rounded-up quotient of the request's data bits.
    a_symbols_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sym_bits >= past_bits) && (sym_bits - past_bps < past_bits))
        else $error("data symbol count is not the rounded-up quotient");

    // A nonzero duration covers at least the overhead symbols' worth of count.
    a_duration_zero_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && (duration_ns != '0) |-> duration_ns >= ofat_pkg::DURATION_W'(5))
        else $error("duration below five symbols of one nanosecond");

endmodule

bind ofdm_frame_airtime_calc ofat_checker u_ofat_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .length_bytes (length_bytes),
    .rate_index   (rate_index),
    .done         (done),
    .data_symbols (data_symbols),
    .duration_ns  (duration_ns)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OFDM frame airtime calculator testbench
// Sends directed and random requests, predicts the symbol count and airtime
// of each one and checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int LEN_W      = ofat_pkg::LEN_W;
    localparam int RATE_W     = ofat_pkg::RATE_W;
    localparam int SYMTIME_W  = ofat_pkg::SYMTIME_W;
    localparam int SYMBOLS_W  = ofat_pkg::SYMBOLS_W;
    localparam int DURATION_W = ofat_pkg::DURATION_W;

    localparam int PIPE_LATENCY   = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 195;

    localparam int unsigned SERVICE_TAIL_BITS  = 22;
    localparam int unsigned PREAMBLE_HDR_SYMS  = 5;
    localparam logic [SYMTIME_W-1:0] SYMTIME_AT_RESET = 14'd4000;
    localparam logic [SYMTIME_W-1:0] SYMTIME_MAX      = '1;
    localparam logic [LEN_W-1:0]     LENGTH_MAX       = '1;

    localparam int unsigned DATA_BITS_PER_SYMBOL [8] = '{24, 36, 48, 72, 96, 144, 192, 216};

    typedef struct {
        logic [LEN_W-1:0]      length;
        logic [RATE_W-1:0]     rate;
        logic [SYMBOLS_W-1:0]  symbols;
        logic [DURATION_W-1:0] duration;
    } airtime_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [LEN_W-1:0]      length_bytes = '0;
    logic [RATE_W-1:0]     rate_index = '0;
    logic                  cfg_we = 1'b0;
    logic [SYMTIME_W-1:0]  cfg_wdata = '0;
    logic                  done;
    logic [SYMBOLS_W-1:0]  data_symbols;
    logic [DURATION_W-1:0] duration_ns;

    airtime_t             pending_airtime[$];
    logic [SYMTIME_W-1:0] cur_symbol_time = SYMTIME_AT_RESET;
    int                   fail_count = 0;
    int                   report_count = 0;
    int                   quiet_cycles = 0;
    int                   burst_left = 0;

    ofdm_frame_airtime_calc dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .length_bytes (length_bytes),
        .rate_index   (rate_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .data_symbols (data_symbols),
        .duration_ns  (duration_ns)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic airtime_t predict_airtime(input logic [LEN_W-1:0] len,
                                                 input logic [RATE_W-1:0] rate,
                                                 input logic [SYMTIME_W-1:0] sym_ns);
        airtime_t        r;
        int unsigned     per_sym;
        int unsigned     total_bits;
        int unsigned     symbols;
        longint unsigned airtime;
        per_sym    = DATA_BITS_PER_SYMBOL[rate];
        total_bits = SERVICE_TAIL_BITS + 8 * int'(len);
        symbols    = (total_bits + per_sym - 1) / per_sym;
        airtime    = longint'(PREAMBLE_HDR_SYMS + symbols) * longint'(sym_ns);
        r.length   = len;
        r.rate     = rate;
        r.symbols  = SYMBOLS_W'(symbols);
        r.duration = DURATION_W'(airtime);
        return r;
    endfunction

    // Predictions, result checks and the watchdog share one process, so the
    // order of a push and a pop at the same clock edge is fixed.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_airtime.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected result: symbols %0d duration %0d",
                             data_symbols, duration_ns);
                report_count++;
            end
            else
            begin
                airtime_t exp_r;
                exp_r = pending_airtime.pop_front();
                if (data_symbols !== exp_r.symbols || duration_ns !== exp_r.duration)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display({"mismatch for length %0d rate %0d: ",
                                  "symbols exp %0d got %0d, duration exp %0d got %0d"},
                                 exp_r.length, exp_r.rate, exp_r.symbols, data_symbols,
                                 exp_r.duration, duration_ns);
                    report_count++;
                end
            end
        end
        if (rst_n && start && !busy)
            pending_airtime.push_back(predict_airtime(length_bytes, rate_index,
                                                      cur_symbol_time));
        if (rst_n && cfg_we)
            cur_symbol_time = cfg_wdata;

        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     pending_airtime.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle gaps are drawn per request, with occasional bursts that have none.
    task automatic send_request(input logic [LEN_W-1:0] len, input logic [RATE_W-1:0] rate);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            burst_left = $urandom_range(16, 64);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        length_bytes <= len;
        rate_index   <= rate;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_airtime.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_symbol_time(input logic [SYMTIME_W-1:0] value);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Shortest and longest payloads at every rate, using the reset symbol time.
    task automatic test_reset_symbol_time();
        for (int r = 0; r < 8; r++)
        begin
            send_request('0, RATE_W'(r));
            send_request(LENGTH_MAX, RATE_W'(r));
        end
    endtask

    // Symbol time at its largest, at zero (below range), at one and at the top
    // of the stated range.
    task automatic test_symbol_time_extremes();
        write_symbol_time(SYMTIME_MAX);
        send_request(LENGTH_MAX, 3'd0);
        send_request('0, 3'd7);
        write_symbol_time('0);
        send_request(LENGTH_MAX, 3'd0);
        send_request(12'd1, 3'd4);
        write_symbol_time(14'd1);
        send_request(12'd2, 3'd0);
        send_request(LENGTH_MAX, 3'd7);
        write_symbol_time(14'd16000);
        send_request(LENGTH_MAX, 3'd0);
        send_request(12'd53, 3'd5);
    endtask

    task automatic test_random_traffic();
        logic [SYMTIME_W-1:0] sym_ns;
        logic [LEN_W-1:0]     len;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: sym_ns = SYMTIME_MAX;
                1: sym_ns = 14'd1;
                2: sym_ns = '0;
                3: sym_ns = 14'd16000;
                4: sym_ns = SYMTIME_AT_RESET;
                default: sym_ns = ($urandom_range(0, 1) == 0) ?
                                  SYMTIME_W'($urandom_range(1, 16000)) :
                                  SYMTIME_W'($urandom_range(0, 16383));
            endcase
            write_symbol_time(sym_ns);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       len = LEN_W'($urandom_range(0, 64));
                    1:       len = LEN_W'($urandom_range(4000, 4095));
                    default: len = LEN_W'($urandom_range(0, 4095));
                endcase
                send_request(len, RATE_W'($urandom_range(0, 7)));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_symbol_time();
        test_symbol_time_extremes();
        test_random_traffic();

        wait_for_drain();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
